/* rtl/bbr_pkg.sv */
// Shared types and codes for the bitstream bit reader.
package bbr_pkg;

  // Item kinds.
  localparam logic [2:0] KIND_LOAD   = 3'd0;
  localparam logic [2:0] KIND_SETPOS = 3'd1;
  localparam logic [2:0] KIND_BITS   = 3'd2;
  localparam logic [2:0] KIND_W8     = 3'd3;
  localparam logic [2:0] KIND_W16    = 3'd4;
  localparam logic [2:0] KIND_W24    = 3'd5;
  localparam logic [2:0] KIND_W32    = 3'd6;
  localparam logic [2:0] KIND_W64    = 3'd7;

  // Result status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_SHORT = 2'd1;
  localparam logic [1:0] STAT_ALIGN = 2'd2;
  localparam logic [1:0] STAT_BAD   = 2'd3;

  // Configuration register indexes.
  localparam logic REG_BIG_ENDIAN   = 1'b0;
  localparam logic REG_BUFFER_BYTES = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_FINISH
  } state_t;

  // Number of buffer bytes taken by a word read kind.
  function automatic logic [3:0] word_bytes(input logic [2:0] k);
    logic [3:0] n;
    case (k)
      KIND_W8:  n = 4'd1;
      KIND_W16: n = 4'd2;
      KIND_W24: n = 4'd3;
      KIND_W32: n = 4'd4;
      KIND_W64: n = 4'd8;
      default:  n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

/* rtl/bitstream_bit_reader.sv */
// Top level of the bitstream bit reader: byte buffer, bit cursor and read sequencer.
//
// Usage. Items arrive on the input channel (in_valid/in_ready) and each one
// produces exactly one result transfer on the output channel
// (out_valid/out_ready). A load item writes one byte into the internal buffer,
// a set position item moves the bit cursor, and read items return 1 to 32 bits
// MSB-first or an aligned 8/16/24/32/64 bit word in the configured byte order.
// Two registers, big_endian and buffer_bytes, sit on the APB-style port at
// byte addresses 0 and 4. The user must see that they are written only while
// the block is idle; the block itself does not enforce this.
//
// Timing. Load, set position and rejected reads go straight to the finish
// state, which loads the output register. A successful read that touches nb
// buffer bytes (1 to 5 for a bit read, 1 to 8 for a word read) passes through
// the read state, where the single buffer read port fetches one byte per cycle
// and the read data is registered; one shared shift and mask stage finishes
// the result. A new item is taken only in the idle state.
//
// Reset clears the cursor, the sequencer and the output valid flag and loads
// the register defaults; buffer contents are undefined until loaded. While the
// receiver stalls, the result holds in the output register; the block still
// accepts one more item and completes it as soon as the output register drains.
module bitstream_bit_reader
  import bbr_pkg::*;
#(
  parameter int BUF_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [11:0] addr,
  input  logic [7:0]  load_byte,
  input  logic [14:0] position,
  input  logic [5:0]  width,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] value,
  output logic [1:0]  status,
  output logic [15:0] cursor,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(BUF_BYTES);

  // Configuration registers.
  logic        big_endian;
  logic [12:0] buffer_bytes;

  // Sequencer and item state.
  state_t      state, state_next;
  logic [15:0] bit_cursor;
  logic [15:0] cur_new;      // cursor value once this item completes
  logic [1:0]  item_status;
  logic [63:0] acc;          // gathered bytes
  logic [63:0] mask;         // all zeros for items that return no bits
  logic [6:0]  sh;           // right shift applied to the gathered bytes
  logic        top_ins;      // little-endian word: bytes enter at the top
  logic [AW-1:0] rd_ptr;
  logic [3:0]  issue_left;
  logic [3:0]  recv_left;
  logic        pending;
  logic [7:0]  rdata;

  logic [7:0]  mem [BUF_BYTES];

  // Handshake and control strobes.
  logic in_fire;
  logic rd_en;
  logic finish_fire;
  logic cfg_wr;

  assign in_fire = in_valid && in_ready;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // The register is selected by the word address bit alone.
  always_comb begin
    case (paddr[2])
      REG_BIG_ENDIAN:   prdata = {31'd0, big_endian};
      REG_BUFFER_BYTES: prdata = {19'd0, buffer_bytes};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      big_endian   <= 1'b1;
      buffer_bytes <= 13'd4096;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_BIG_ENDIAN) begin
        big_endian <= pwdata[0];
      end else begin
        buffer_bytes <= pwdata[12:0];
      end
    end
  end

  // Item decode at acceptance: limits, checks, byte count and final shift.
  logic [12:0] lim_bytes;
  logic [15:0] lim_bits;
  logic [15:0] bits_left;
  logic [2:0]  off;
  logic [3:0]  nb_c;
  logic [6:0]  sh_c;
  logic [63:0] mask_c;
  logic [1:0]  status_c;
  logic [15:0] cur_new_c;
  logic        read_c;
  logic [6:0]  span;
  logic [6:0]  need;
  logic [31:0] addr_ext;
  logic [31:0] cur_byte;
  logic        load_ok;

  assign lim_bytes = ({4'd0, buffer_bytes} > 17'(BUF_BYTES)) ? 13'(BUF_BYTES) : buffer_bytes;
  assign lim_bits  = {lim_bytes, 3'b000};
  assign bits_left = (bit_cursor < lim_bits) ? (lim_bits - bit_cursor) : 16'd0;
  assign off       = bit_cursor[2:0];
  assign addr_ext  = 32'(addr);
  assign cur_byte  = 32'(bit_cursor[15:3]);
  assign load_ok   = {5'd0, addr} < 17'(BUF_BYTES);

  always_comb begin
    nb_c      = 4'd0;
    sh_c      = 7'd0;
    mask_c    = 64'd0;
    status_c  = STAT_OK;
    cur_new_c = bit_cursor;
    read_c    = 1'b0;
    span      = 7'(off) + 7'(width) + 7'd7;
    need      = 7'd0;
    case (kind)
      KIND_LOAD: begin
      end
      KIND_SETPOS: begin
        if ({1'b0, position} < lim_bits) begin
          cur_new_c = {1'b0, position};
        end else begin
          status_c = STAT_BAD;
        end
      end
      KIND_BITS: begin
        need = {1'b0, width};
        if (width == 6'd0 || width > 6'd32) begin
          status_c = STAT_BAD;
        end else if ({9'd0, need} > bits_left) begin
          status_c = STAT_SHORT;
        end else begin
          read_c    = 1'b1;
          nb_c      = span[6:3];
          sh_c      = {span[6:3], 3'b000} - 7'(off) - 7'(width);
          mask_c    = ~(64'hFFFF_FFFF_FFFF_FFFF << width);
          cur_new_c = bit_cursor + 16'(width);
        end
      end
      default: begin
        need = {word_bytes(kind), 3'b000};
        if (off != 3'd0) begin
          status_c = STAT_ALIGN;
        end else if ({9'd0, need} > bits_left) begin
          status_c = STAT_SHORT;
        end else begin
          read_c    = 1'b1;
          nb_c      = word_bytes(kind);
          sh_c      = big_endian ? 7'd0 : (7'd64 - need);
          mask_c    = 64'hFFFF_FFFF_FFFF_FFFF;
          cur_new_c = bit_cursor + 16'(need);
        end
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = read_c ? ST_READ : ST_FINISH;
        end
      end
      ST_READ: begin
        if (pending && recv_left == 4'd1) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready    = 1'b0;
    rd_en       = 1'b0;
    finish_fire = 1'b0;
    case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_READ:   rd_en = (issue_left != 4'd0);
      ST_FINISH: finish_fire = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Buffer memory: loads write at acceptance, reads issue one byte a cycle.
  always_ff @(posedge clk) begin
    if (in_fire && kind == KIND_LOAD && load_ok) begin
      mem[addr_ext[AW-1:0]] <= load_byte;
    end
    if (rd_en) begin
      rdata <= mem[rd_ptr];
    end
  end

  // Item registers and the byte gathering loop.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= 1'b0;
      issue_left <= 4'd0;
      recv_left  <= 4'd0;
    end else begin
      pending <= rd_en;
      if (in_fire) begin
        issue_left <= nb_c;
        recv_left  <= nb_c;
      end else begin
        if (rd_en) begin
          issue_left <= issue_left - 4'd1;
        end
        if (pending) begin
          recv_left <= recv_left - 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      acc         <= 64'd0;
      mask        <= mask_c;
      sh          <= sh_c;
      top_ins     <= (kind != KIND_BITS) && !big_endian;
      item_status <= status_c;
      cur_new     <= cur_new_c;
      rd_ptr      <= cur_byte[AW-1:0];
    end else begin
      if (rd_en) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (pending) begin
        acc <= top_ins ? {rdata, acc[63:8]} : {acc[55:0], rdata};
      end
    end
  end

  // Cursor and output register; the shared shift and mask finish the value.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cursor <= 16'd0;
      out_valid  <= 1'b0;
    end else begin
      if (finish_fire) begin
        bit_cursor <= cur_new;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish_fire) begin
      value  <= (acc >> sh) & mask;
      status <= item_status;
      cursor <= cur_new;
    end
  end

endmodule

/* sim/bbr_checker.sv */
// Result predictor and comparator for the bitstream bit reader channels.
module bbr_checker
  import bbr_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_ready,
  input  logic [2:0]      kind,
  input  logic [11:0]     addr,
  input  logic [7:0]      load_byte,
  input  logic [14:0]     position,
  input  logic [5:0]      width,
  input  logic            out_valid,
  input  logic            out_ready,
  input  logic [63:0]     value,
  input  logic [1:0]      status,
  input  logic [15:0]     cursor,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  input  logic            pready,
  output int unsigned     fail_count,
  output int unsigned     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MEM_BYTES         = 4096;
  localparam logic [2:0]  ADDR_BIG_ENDIAN   = {REG_BIG_ENDIAN, 2'b00};
  localparam logic [2:0]  ADDR_BUFFER_BYTES = {REG_BUFFER_BYTES, 2'b00};

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
    logic [15:0] cursor;
  } read_result_t;

  // Mirror of the block's buffer, cursor and registers.
  logic [7:0]   mirror_mem [MEM_BYTES];
  logic [15:0]  mirror_cursor;
  logic         mirror_be;
  logic [12:0]  mirror_bytes;

  read_result_t awaited_results [$];
  read_result_t oldest;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic int unsigned readable_bits();
    int unsigned n;
    n = (mirror_bytes > MEM_BYTES) ? MEM_BYTES : mirror_bytes;
    return n * 8;
  endfunction

  function automatic int unsigned remaining_bits();
    int unsigned lim;
    lim = readable_bits();
    return (mirror_cursor < lim) ? lim - mirror_cursor : 0;
  endfunction

  function automatic logic [7:0] mem_byte(input int unsigned idx);
    return (idx < MEM_BYTES) ? mirror_mem[idx] : 8'h00;
  endfunction

  // Applies one item to the mirror and returns the result it must produce.
  function automatic read_result_t advance_reader(input logic [2:0] k,
                                                  input logic [11:0] a,
                                                  input logic [7:0] b,
                                                  input logic [14:0] p,
                                                  input logic [5:0] w);
    read_result_t r;
    logic [7:0]   fetched;
    int unsigned  nbytes;
    int unsigned  base;
    r.value  = '0;
    r.status = STAT_OK;
    case (k)
      KIND_LOAD: begin
        mirror_mem[a] = b;
      end
      KIND_SETPOS: begin
        if (p < readable_bits()) mirror_cursor = {1'b0, p};
        else r.status = STAT_BAD;
      end
      KIND_BITS: begin
        if (w == 6'd0 || w > 6'd32) begin
          r.status = STAT_BAD;
        end else if (remaining_bits() < w) begin
          r.status = STAT_SHORT;
        end else begin
          for (int i = 0; i < w; i++) begin
            fetched = mem_byte(mirror_cursor >> 3);
            r.value = {r.value[62:0], fetched[3'd7 - mirror_cursor[2:0]]};
            mirror_cursor++;
          end
        end
      end
      default: begin
        case (k)
          KIND_W8:  nbytes = 1;
          KIND_W16: nbytes = 2;
          KIND_W24: nbytes = 3;
          KIND_W32: nbytes = 4;
          default:  nbytes = 8;
        endcase
        if (mirror_cursor[2:0] != 3'd0) begin
          r.status = STAT_ALIGN;
        end else if (remaining_bits() < nbytes * 8) begin
          r.status = STAT_SHORT;
        end else begin
          base = mirror_cursor >> 3;
          for (int j = 0; j < nbytes; j++) begin
            fetched = mem_byte(base + j);
            if (mirror_be) r.value = {r.value[55:0], fetched};
            else r.value[8*j +: 8] = fetched;
          end
          mirror_cursor = mirror_cursor + 16'(nbytes * 8);
        end
      end
    endcase
    r.cursor = mirror_cursor;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mirror_cursor = '0;
      mirror_be     = 1'b1;
      mirror_bytes  = 13'd4096;
      awaited_results.delete();
      pending       = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_BIG_ENDIAN) mirror_be = pwdata[0];
        else if (paddr == ADDR_BUFFER_BYTES) mirror_bytes = pwdata[12:0];
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with none expected: value %h status %0d cursor %0d",
                   $time, value, status, cursor);
          fail_count++;
        end else begin
          oldest = awaited_results.pop_front();
          if (value !== oldest.value) begin
            $display("%0t: value expected %h actual %h", $time, oldest.value, value);
            fail_count++;
          end
          if (status !== oldest.status) begin
            $display("%0t: status expected %0d actual %0d", $time, oldest.status, status);
            fail_count++;
          end
          if (cursor !== oldest.cursor) begin
            $display("%0t: cursor expected %0d actual %0d", $time, oldest.cursor, cursor);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        awaited_results.push_back(advance_reader(kind, addr, load_byte, position, width));
      pending = awaited_results.size();
    end
  end

endmodule

/* sim/tb_top.sv */
// Top of the bitstream bit reader testbench: clock, reset, stimulus and verdict.
module tb_top
  import bbr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ADDR_BIG_ENDIAN   = {REG_BIG_ENDIAN, 2'b00};
  localparam logic [2:0] ADDR_BUFFER_BYTES = {REG_BUFFER_BYTES, 2'b00};
  localparam int         MEM_BYTES         = 4096;

  // Each phase selects a byte order and a buffer size, then runs a number of
  // random items. The sizes include an empty buffer and a single byte, and
  // some phases shrink the buffer below the cursor left by the one before.
  localparam int PHASES = 9;
  int phase_be    [PHASES] = '{0, 1, 0, 1, 1, 0, 1, 0, 1};
  int phase_bytes [PHASES] = '{16, 0, 64, 1, 200, 120, 256, 2, 256};
  int phase_items [PHASES] = '{120, 30, 160, 50, 200, 180, 160, 80, 70};

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [2:0]  kind      = KIND_LOAD;
  logic [11:0] addr      = '0;
  logic [7:0]  load_byte = '0;
  logic [14:0] position  = '0;
  logic [5:0]  width     = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] value;
  logic [1:0]  status;
  logic [15:0] cursor;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count;
  int unsigned pending;

  // Stimulus bookkeeping. Bytes below loaded_bytes have all been written, and
  // the buffer size register is never raised past that mark, so no read can
  // ever reach a byte that was never loaded.
  int unsigned loaded_bytes = 0;
  int unsigned cfg_bytes    = 4096;
  bit          tx_calm      = 1'b0;
  bit          rx_calm      = 1'b0;
  int unsigned rx_wait      = 0;
  int unsigned rx_draw;

  bitstream_bit_reader uut (.*);
  bbr_checker chk (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver side. After every result transfer it draws a random stall, possibly
  // none; now and then it switches into a calm stretch where it never stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
    end else if (out_valid && out_ready) begin
      if ($urandom_range(0, 149) == 0) rx_calm <= !rx_calm;
      rx_draw = rx_calm ? 0 : $urandom_range(0, 19);
      if (rx_draw != 0) begin
        out_ready <= 1'b0;
        rx_wait   <= rx_draw;
      end
    end else if (!out_ready) begin
      if (rx_wait > 1) rx_wait <= rx_wait - 1;
      else out_ready <= 1'b1;
    end
  end

  // Sends one item. The caller is at a rising edge; the task returns at the
  // edge where the transfer happened, with valid still high so that a
  // back-to-back item keeps it high without a glitch.
  task automatic push_item(input logic [2:0] k, input logic [11:0] a,
                           input logic [7:0] b, input logic [14:0] p,
                           input logic [5:0] w);
    int unsigned gap;
    if ($urandom_range(0, 99) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    kind      <= k;
    addr      <= a;
    load_byte <= b;
    position  <= p;
    width     <= w;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops sending and waits until every result has been taken. The checker
  // updates its count at the rising edge, so it is looked at on the falling one.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; the bus returns to rest before the task returns.
  task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Loads random bytes up to the given count, extending the written region.
  task automatic fill_buffer(input int unsigned upto);
    for (int unsigned i = loaded_bytes; i < upto; i++)
      push_item(KIND_LOAD, 12'(i), 8'($urandom), 15'($urandom), 6'($urandom));
    if (upto > loaded_bytes) loaded_bytes = upto;
  endtask

  // One random item. Most are reads and cursor moves that stay inside the
  // readable range, so that reads actually succeed; a minority use any field
  // value at all. Fields that the kind ignores still get random values.
  task automatic random_item(input int unsigned lim_bits);
    int unsigned pick;
    int unsigned sub;
    int unsigned back;
    logic [14:0] pos;
    logic [5:0]  w;
    logic [2:0]  k;
    pick = $urandom_range(0, 99);
    pos  = 15'($urandom);
    w    = 6'($urandom);
    if (pick < 8) begin
      k = KIND_LOAD;
    end else if (pick < 22) begin
      k   = KIND_SETPOS;
      sub = $urandom_range(0, 9);
      if (lim_bits != 0 && sub != 0) begin
        if (sub < 4) begin
          pos = 15'(($urandom % lim_bits) & ~32'd7);
        end else if (sub < 6) begin
          // Close to the end, so later reads run short.
          back = $urandom_range(1, 80);
          pos  = (back >= lim_bits) ? 15'd0 : 15'(lim_bits - back);
        end else begin
          pos = 15'($urandom % lim_bits);
        end
      end
    end else if (pick < 55) begin
      k = KIND_BITS;
      w = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                      : 6'($urandom_range(1, 32));
    end else begin
      k = 3'($urandom_range(KIND_W8, KIND_W64));
    end
    push_item(k, 12'($urandom), 8'($urandom), pos, w);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on a 16-byte buffer in big-endian order.
    apb_write(ADDR_BIG_ENDIAN, 32'd1);
    apb_write(ADDR_BUFFER_BYTES, 32'd16);
    cfg_bytes = 16;
    fill_buffer(16);
    push_item(KIND_LOAD,   12'd4095, 8'hFF, 15'd0,     6'd0);  // highest address
    push_item(KIND_LOAD,   12'd0,    8'hFF, 15'd0,     6'd0);
    push_item(KIND_LOAD,   12'd1,    8'h00, 15'd0,     6'd0);
    push_item(KIND_SETPOS, 12'd0,    8'd0,  15'd0,     6'd0);
    push_item(KIND_BITS,   12'd0,    8'd0,  15'd0,     6'd32); // widest bit read
    push_item(KIND_SETPOS, 12'd0,    8'd0,  15'd127,   6'd0);  // last valid bit
    push_item(KIND_BITS,   12'd0,    8'd0,  15'd0,     6'd1);
    push_item(KIND_BITS,   12'd0,    8'd0,  15'd0,     6'd1);  // nothing left
    push_item(KIND_W8,     12'd0,    8'd0,  15'd0,     6'd0);  // aligned but short
    push_item(KIND_SETPOS, 12'd0,    8'd0,  15'd128,   6'd0);  // one past the end
    push_item(KIND_SETPOS, 12'd0,    8'd0,  15'd32767, 6'd0);  // largest position
    push_item(KIND_SETPOS, 12'd0,    8'd0,  15'd5,     6'd0);
    push_item(KIND_BITS,   12'd0,    8'd0,  15'd0,     6'd0);  // zero width
    push_item(KIND_BITS,   12'd0,    8'd0,  15'd0,     6'd33);
    push_item(KIND_BITS,   12'd0,    8'd0,  15'd0,     6'd63);
    push_item(KIND_W16,    12'd0,    8'd0,  15'd0,     6'd0);  // misaligned word
    push_item(KIND_BITS,   12'd0,    8'd0,  15'd0,     6'd32); // spans five bytes
    push_item(KIND_SETPOS, 12'd0,    8'd0,  15'd0,     6'd0);
    push_item(KIND_W8,     12'd0,    8'd0,  15'd0,     6'd0);
    push_item(KIND_W16,    12'd0,    8'd0,  15'd0,     6'd0);
    push_item(KIND_W24,    12'd0,    8'd0,  15'd0,     6'd0);
    push_item(KIND_W32,    12'd0,    8'd0,  15'd0,     6'd0);
    push_item(KIND_W64,    12'd0,    8'd0,  15'd0,     6'd0);  // only six bytes left
    push_item(KIND_SETPOS, 12'd0,    8'd0,  15'd64,    6'd0);
    push_item(KIND_W64,    12'd0,    8'd0,  15'd0,     6'd0);
    // A bad width wins over a short buffer, and a misaligned word does too.
    push_item(KIND_SETPOS, 12'd0,    8'd0,  15'd125,   6'd0);
    push_item(KIND_BITS,   12'd0,    8'd0,  15'd0,     6'd33);
    push_item(KIND_W32,    12'd0,    8'd0,  15'd0,     6'd0);
    push_item(KIND_BITS,   12'd0,    8'd0,  15'd0,     6'd4);

    // Random phases. Registers change only once the block has drained. When
    // the size drops below the cursor, the next reads see no bits left.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      apb_write(ADDR_BIG_ENDIAN, 32'(phase_be[ph]));
      apb_write(ADDR_BUFFER_BYTES, 32'(phase_bytes[ph]));
      cfg_bytes = phase_bytes[ph];
      fill_buffer((cfg_bytes > MEM_BYTES) ? MEM_BYTES : cfg_bytes);
      for (int n = 0; n < phase_items[ph]; n++) begin
        // Halfway through, the sender holds off until everything has come back.
        if (n == phase_items[ph] / 2) wait_idle();
        random_item(((cfg_bytes > MEM_BYTES) ? MEM_BYTES : cfg_bytes) * 8);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("bitstream_bit_reader test passed");
    end else begin
      $display("bitstream_bit_reader test failed");
    end
    $finish;
  end

  // Safety net: a hang or a result that never arrives ends the run here.
  initial begin
    #15ms;
    $display("bitstream_bit_reader test failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/bbr_pkg.sv
rtl/bitstream_bit_reader.sv
sim/bbr_checker.sv
sim/tb_top.sv
